/* design/vcas_pkg.sv */
package vcas_pkg;

  // operation codes carried by an input item
  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_START  = 3'd1,
    OP_STOP   = 3'd2,
    OP_PAUSE  = 3'd3,
    OP_RESUME = 3'd4,
    OP_LOSS   = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_FILL,
    ST_SEARCH,
    ST_LOSS
  } state_t;

  // configuration register indexes
  localparam logic [1:0] REG_DWELL     = 2'd0;
  localparam logic [1:0] REG_LOSS_SKIP = 2'd1;
  localparam logic [1:0] REG_PIP       = 2'd2;

  localparam logic [31:0] DWELL_RESET = 32'h0303_0303;
  localparam logic [7:0]  SKIP_MARK   = 8'hFF;
  localparam logic [7:0]  TIME_ZERO   = 8'h00;
  localparam logic [7:0]  TIME_ONE    = 8'h01;

  typedef struct packed {
    logic [31:0] dwell_times;
    logic        loss_skip_enable;
    logic        pip_sequence_mode;
  } cfg_t;

endpackage

/* design/vcas_time_mem.sv */
module vcas_time_mem #(
  parameter int CHANNELS = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        clr,
  input  logic                        we,
  input  logic [$clog2(CHANNELS)-1:0] waddr,
  input  logic [7:0]                  wdata,
  input  logic [$clog2(CHANNELS)-1:0] raddr,
  output logic [7:0]                  rdata
);
  import vcas_pkg::*;

  logic [7:0]          mem [CHANNELS];
  logic [CHANNELS-1:0] vld;
  logic [7:0]          rd_q;
  logic                rd_vld;
  logic                fwd;

  // same-entry write and read in one cycle returns the new value
  assign fwd = we && (waddr == raddr);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // entry not written since reset or clear reads as zero
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_q   <= fwd ? wdata : mem[raddr];
    rd_vld <= fwd || vld[raddr];
  end

  assign rdata = rd_vld ? rd_q : TIME_ZERO;

endmodule

/* design/vcas_ctrl.sv */
module vcas_ctrl #(
  parameter int CHANNELS = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  vcas_pkg::cfg_t              cfg,
  input  logic                        start,
  input  logic [2:0]                  operation,
  input  logic [3:0]                  loss_mask,
  input  logic [1:0]                  start_channel,
  output logic                        busy,
  output logic                        done,
  output logic [1:0]                  shown_channel,
  output logic                        running,
  output logic                        held,
  output logic                        switched,
  output logic                        mem_clr,
  output logic                        mem_we,
  output logic [$clog2(CHANNELS)-1:0] mem_waddr,
  output logic [7:0]                  mem_wdata,
  output logic [$clog2(CHANNELS)-1:0] mem_raddr,
  input  logic [7:0]                  mem_rdata
);
  import vcas_pkg::*;

  localparam int CW = $clog2(CHANNELS);
  localparam logic [CW-1:0] LAST = CW'(CHANNELS - 1);
  localparam logic [CW-1:0] CH_ZERO = CW'(0);
  localparam logic [CW-1:0] CH_ONE = CW'(1);

  state_t         state, state_next;
  op_t            op_q, op_q_next;
  logic [3:0]     loss_q, loss_q_next;
  logic [3:0]     chg, chg_next;
  logic [CW-1:0]  base, base_next;
  logic [CW-1:0]  cand, cand_next;
  logic [CW-1:0]  cnt, cnt_next;
  logic [CW-1:0]  idx, idx_next;
  logic [CW-1:0]  cur, cur_next;
  logic [CW-1:0]  prior, prior_next;
  logic           active, active_next;
  logic           pause, pause_next;
  logic [3:0]     prev, prev_next;
  logic           fin;

  function automatic logic [CW-1:0] wrap_inc(input logic [CW-1:0] x);
    return (x == LAST) ? CH_ZERO : x + CH_ONE;
  endfunction

  // successor on a tick: channel 0 is stepped over in PIP mode
  function automatic logic [CW-1:0] tick_succ(input logic [CW-1:0] x, input logic pip);
    logic [CW-1:0] w;
    w = wrap_inc(x);
    if (pip && w == CH_ZERO) begin
      w = CH_ONE;
    end
    return w;
  endfunction

  // bytes past the 32-bit register shift out to zero
  function automatic logic [7:0] dwell_of(input logic [31:0] dw, input logic [CW-1:0] ch);
    return 8'(dw >> {ch, 3'b000});
  endfunction

  function automatic logic bit_of(input logic [3:0] m, input logic [CW-1:0] ch);
    logic [3:0] t;
    t = m >> ch;
    return t[0];
  endfunction

  assign busy = (state != ST_IDLE);

  always_comb begin
    logic          skip;
    logic          pip;
    logic [3:0]    s4;
    logic [CW-1:0] cand_start;
    logic [CW-1:0] nxt;
    logic [7:0]    v;
    logic          ok;

    skip = cfg.loss_skip_enable;
    pip  = cfg.pip_sequence_mode;

    state_next  = state;
    op_q_next   = op_q;
    loss_q_next = loss_q;
    chg_next    = chg;
    base_next   = base;
    cand_next   = cand;
    cnt_next    = cnt;
    idx_next    = idx;
    cur_next    = cur;
    prior_next  = prior;
    active_next = active;
    pause_next  = pause;
    prev_next   = prev;
    fin         = 1'b0;
    mem_clr     = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = idx;
    mem_wdata   = TIME_ZERO;
    mem_raddr   = cand;
    nxt         = cand;
    v           = mem_rdata;
    ok          = 1'b0;

    // start channel modulo CHANNELS; two subtractions cover a 2-bit value
    s4 = 4'(start_channel);
    if (s4 >= 4'(CHANNELS)) begin
      s4 = s4 - 4'(CHANNELS);
    end
    if (s4 >= 4'(CHANNELS)) begin
      s4 = s4 - 4'(CHANNELS);
    end
    if (active) begin
      cand_start = wrap_inc(cur);
    end else if (pip) begin
      cand_start = CH_ONE;
    end else begin
      cand_start = CW'(s4);
    end

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          op_q_next   = op_t'(operation);
          loss_q_next = loss_mask;
          prior_next  = cur;
          case (op_t'(operation))
            OP_TICK: begin
              if (active) begin
                mem_raddr  = cur;
                state_next = ST_TICK;
              end else begin
                fin = 1'b1;
              end
            end
            OP_START: begin
              pause_next = 1'b0;
              if (active) begin
                prev_next = skip ? loss_mask : 4'h0;
              end
              idx_next   = CH_ZERO;
              base_next  = cand_start;
              state_next = ST_FILL;
            end
            OP_STOP: begin
              pause_next  = 1'b0;
              active_next = 1'b0;
              prev_next   = 4'h0;
              mem_clr     = 1'b1;
              fin         = 1'b1;
            end
            OP_PAUSE: begin
              pause_next = 1'b1;
              fin        = 1'b1;
            end
            OP_RESUME: begin
              pause_next = 1'b0;
              fin        = 1'b1;
            end
            OP_LOSS: begin
              if (active && skip) begin
                chg_next   = prev ^ loss_mask;
                prev_next  = loss_mask;
                idx_next   = CH_ZERO;
                state_next = ST_LOSS;
              end else begin
                if (active) begin
                  prev_next = 4'h0;
                end
                fin = 1'b1;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      ST_TICK: begin
        if (v == SKIP_MARK) begin
          fin = 1'b1;
        end else if (v != TIME_ZERO) begin
          if (!pause) begin
            mem_we    = 1'b1;
            mem_waddr = cur;
            mem_wdata = 8'(v - TIME_ONE);
          end
          fin = 1'b1;
        end else begin
          // expired: reload, then look for the next channel
          mem_we     = 1'b1;
          mem_waddr  = cur;
          mem_wdata  = dwell_of(cfg.dwell_times, cur);
          nxt        = tick_succ(cur, pip);
          cand_next  = nxt;
          mem_raddr  = nxt;
          cnt_next   = CH_ZERO;
          state_next = ST_SEARCH;
        end
      end

      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = idx;
        if (pip && idx == CH_ZERO) begin
          mem_wdata = TIME_ZERO;
        end else if (skip && bit_of(loss_q, idx)) begin
          mem_wdata = SKIP_MARK;
        end else begin
          mem_wdata = dwell_of(cfg.dwell_times, idx);
        end
        if (idx == LAST) begin
          cand_next  = base;
          mem_raddr  = base;
          cnt_next   = CH_ZERO;
          state_next = ST_SEARCH;
        end else begin
          idx_next = idx + CH_ONE;
        end
      end

      ST_SEARCH: begin
        if (op_q == OP_START) begin
          ok = !(v == TIME_ZERO || (v == SKIP_MARK && skip));
        end else begin
          ok = (v != TIME_ZERO) && (v != SKIP_MARK);
        end
        if (ok) begin
          cur_next = cand;
          if (op_q == OP_START) begin
            active_next = 1'b1;
          end
          fin = 1'b1;
        end else if (cnt == LAST) begin
          // nothing eligible: start keeps its first candidate, tick stays put
          if (op_q == OP_START) begin
            cur_next    = base;
            active_next = 1'b1;
          end
          fin = 1'b1;
        end else begin
          nxt       = (op_q == OP_START) ? wrap_inc(cand) : tick_succ(cand, pip);
          cnt_next  = cnt + CH_ONE;
          cand_next = nxt;
          mem_raddr = nxt;
        end
      end

      ST_LOSS: begin
        if (bit_of(chg, idx)) begin
          mem_we    = 1'b1;
          mem_waddr = idx;
          mem_wdata = bit_of(loss_q, idx) ? SKIP_MARK : dwell_of(cfg.dwell_times, idx);
        end
        if (idx == LAST) begin
          fin = 1'b1;
        end else begin
          idx_next = idx + CH_ONE;
        end
      end

      default: begin
        fin = 1'b1;
      end
    endcase

    if (fin) begin
      state_next = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      cur    <= LAST;
      active <= 1'b0;
      pause  <= 1'b0;
      prev   <= 4'h0;
      done   <= 1'b0;
    end else begin
      state  <= state_next;
      cur    <= cur_next;
      active <= active_next;
      pause  <= pause_next;
      prev   <= prev_next;
      done   <= fin;
    end
  end

  always_ff @(posedge clk) begin
    logic [7:0] wide;
    wide   = 8'(cur_next);
    op_q   <= op_q_next;
    loss_q <= loss_q_next;
    chg    <= chg_next;
    base   <= base_next;
    cand   <= cand_next;
    cnt    <= cnt_next;
    idx    <= idx_next;
    prior  <= prior_next;
    if (fin) begin
      shown_channel <= wide[1:0];
      running       <= active_next;
      held          <= pause_next;
      switched      <= (cur_next != prior_next);
    end
  end

  a_write_busy : assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state != ST_IDLE))
    else $error("time store written while idle");

  a_done_idle : assert property (@(posedge clk) disable iff (rst)
    done |-> (state == ST_IDLE))
    else $error("result strobe while still working");

  a_search_bound : assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH) |-> (cnt <= LAST))
    else $error("search ran past the channel count");

  a_start_runs : assert property (@(posedge clk) disable iff (rst)
    (done && op_q == OP_START) |-> (running && !held))
    else $error("start finished without running");

  a_stop_halts : assert property (@(posedge clk) disable iff (rst)
    (done && op_q == OP_STOP) |-> (!running && !held))
    else $error("stop left sequencing active");

endmodule

/* design/video_channel_auto_sequencer.sv */
// Channel    | Direction | Handshake            | Payload
// command    | in        | start, busy          | operation, loss_mask, start_channel
// result     | out       | done (one cycle)     | shown_channel, running, held, switched
// config     | in        | cfg_write            | cfg_index, cfg_data
//
// Stop, pause, resume, unused codes and a tick or loss update with no store
// access are answered without busy rising. A tick reads the current channel's
// time and, when the dwell expires, searches for the next channel; a start
// fills every channel's time, then searches from its first candidate; a loss
// update walks every channel. The time store takes one read and one write a
// cycle. rst is synchronous; the next item is taken at the earliest on the edge
// that ends the done cycle.
// The receiver cannot stall: each result is valid in its done cycle only.
module video_channel_auto_sequencer #(
  parameter int CHANNELS = 4
) (
  input  logic        clk,
  input  logic        rst,
  // configuration writes
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // command
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  operation,
  input  logic [3:0]  loss_mask,
  input  logic [1:0]  start_channel,
  // result
  output logic        done,
  output logic [1:0]  shown_channel,
  output logic        running,
  output logic        held,
  output logic        switched
);
  import vcas_pkg::*;

  localparam int CW = $clog2(CHANNELS);

  cfg_t          cfg;
  logic          mem_clr;
  logic          mem_we;
  logic [CW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [CW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  // configuration registers; index 3 is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dwell_times       <= DWELL_RESET;
      cfg.loss_skip_enable  <= 1'b0;
      cfg.pip_sequence_mode <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DWELL:     cfg.dwell_times       <= cfg_data;
        REG_LOSS_SKIP: cfg.loss_skip_enable  <= cfg_data[0];
        REG_PIP:       cfg.pip_sequence_mode <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // sequencer: owns flags, current channel and the read-modify-write steps
  vcas_ctrl #(
    .CHANNELS(CHANNELS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .start        (start),
    .operation    (operation),
    .loss_mask    (loss_mask),
    .start_channel(start_channel),
    .busy         (busy),
    .done         (done),
    .shown_channel(shown_channel),
    .running      (running),
    .held         (held),
    .switched     (switched),
    .mem_clr      (mem_clr),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata)
  );

  // per-channel remaining seconds (0xFF marks a skipped channel)
  vcas_time_mem #(
    .CHANNELS(CHANNELS)
  ) u_time_mem (
    .clk  (clk),
    .rst  (rst),
    .clr  (mem_clr),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

endmodule

/* test/sequencer_check_pkg.sv */
package sequencer_check_pkg;

  import vcas_pkg::*;

  localparam int NUM_CHANNELS = 4;

  // operation codes the block ignores
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  class sequencer_scoreboard;

    typedef struct packed {
      logic [1:0] shown;
      logic       running;
      logic       held;
      logic       switched;
    } selection_t;

    // register copies
    logic [31:0] dwell_cfg;
    bit          skip_lost;
    bit          pip_mode;

    // sequencer state
    logic [7:0]  time_left[NUM_CHANNELS];
    logic [1:0]  channel;
    bit          active;
    bit          paused;
    logic [3:0]  prev_loss;

    selection_t  expected_selection_q[$];
    int          fails;

    function new();
      dwell_cfg = DWELL_RESET;
      skip_lost = 1'b0;
      pip_mode  = 1'b0;
      foreach (time_left[i]) time_left[i] = TIME_ZERO;
      channel   = 2'(NUM_CHANNELS - 1);
      active    = 1'b0;
      paused    = 1'b0;
      prev_loss = 4'd0;
      fails     = 0;
    endfunction

    function logic [7:0] dwell_of(int ch);
      return dwell_cfg[8*ch +: 8];
    endfunction

    function void write_register(logic [1:0] index, logic [31:0] data);
      case (index)
        REG_DWELL:     dwell_cfg = data;
        REG_LOSS_SKIP: skip_lost = data[0];
        REG_PIP:       pip_mode  = data[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_selection_q.size();
    endfunction

    // advance the sequencer by one command and queue the selection it shows
    function void take_command(logic [2:0] op, logic [3:0] loss, logic [1:0] chan);
      int c;
      int t;
      bit found;
      logic [1:0] prior;
      selection_t sel;
      prior = channel;
      found = 1'b0;
      case (op)
        OP_TICK: begin
          if (active && time_left[channel] != SKIP_MARK) begin
            if (time_left[channel] != TIME_ZERO) begin
              if (!paused) time_left[channel] = time_left[channel] - TIME_ONE;
            end else begin
              time_left[channel] = dwell_of(channel);
              c = channel;
              for (int k = 0; k < NUM_CHANNELS; k++) begin
                if (!found) begin
                  c = (c + 1) % NUM_CHANNELS;
                  if (pip_mode && c == 0) c = 1;
                  if (time_left[c] != TIME_ZERO && time_left[c] != SKIP_MARK) begin
                    channel = c[1:0];
                    found = 1'b1;
                  end
                end
              end
            end
          end
        end
        OP_START: begin
          paused = 1'b0;
          for (int i = 0; i < NUM_CHANNELS; i++)
            time_left[i] = (skip_lost && loss[i]) ? SKIP_MARK : dwell_of(i);
          if (active) prev_loss = skip_lost ? loss : 4'd0;
          if (pip_mode) time_left[0] = TIME_ZERO;
          if (active) c = (channel + 1) % NUM_CHANNELS;
          else if (pip_mode) c = 1 % NUM_CHANNELS;
          else c = chan % NUM_CHANNELS;
          // bounded search; the candidate stays if nothing qualifies
          for (int k = 0; k < NUM_CHANNELS; k++) begin
            if (!found) begin
              t = (c + k) % NUM_CHANNELS;
              if (!(time_left[t] == TIME_ZERO ||
                    (time_left[t] == SKIP_MARK && skip_lost))) begin
                c = t;
                found = 1'b1;
              end
            end
          end
          channel = c[1:0];
          active  = 1'b1;
        end
        OP_STOP: begin
          paused    = 1'b0;
          active    = 1'b0;
          prev_loss = 4'd0;
          foreach (time_left[i]) time_left[i] = TIME_ZERO;
        end
        OP_PAUSE:  paused = 1'b1;
        OP_RESUME: paused = 1'b0;
        OP_LOSS: begin
          if (active) begin
            if (skip_lost) begin
              for (int i = 0; i < NUM_CHANNELS; i++)
                if (prev_loss[i] != loss[i])
                  time_left[i] = loss[i] ? SKIP_MARK : dwell_of(i);
              prev_loss = loss;
            end else begin
              prev_loss = 4'd0;
            end
          end
        end
        default: ;
      endcase
      sel.shown    = channel;
      sel.running  = active;
      sel.held     = paused;
      sel.switched = (channel != prior);
      expected_selection_q.push_back(sel);
    endfunction

    function void check_selection(logic [1:0] shown, logic run, logic hold, logic sw);
      selection_t want;
      if (expected_selection_q.size() == 0) begin
        $error("result with no item waiting");
        fails++;
      end else begin
        want = expected_selection_q.pop_front();
        if (shown !== want.shown) begin
          $error("shown_channel: expected %0d, actual %0d", want.shown, shown);
          fails++;
        end
        if (run !== want.running) begin
          $error("running: expected %0d, actual %0d", want.running, run);
          fails++;
        end
        if (hold !== want.held) begin
          $error("held: expected %0d, actual %0d", want.held, hold);
          fails++;
        end
        if (sw !== want.switched) begin
          $error("switched: expected %0d, actual %0d", want.switched, sw);
          fails++;
        end
      end
    endfunction

  endclass

endpackage

/* test/video_channel_auto_sequencer_test.sv */
module video_channel_auto_sequencer_test;

  timeunit 1ns;
  timeprecision 1ps;

  import vcas_pkg::*;
  import sequencer_check_pkg::*;

  // silence allowed before the run is declared hung; covers the longest gap,
  // the settle time and the slowest item with plenty to spare
  localparam int IDLE_LIMIT = 600;
  // a start fills every channel, then searches for a channel to show
  localparam int SETTLE     = 2 * NUM_CHANNELS + 4;
  localparam int NUM_PHASES = 15;
  localparam int PHASE_ITEMS = 122;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [31:0] cfg_data = 32'd0;
  logic        start = 1'b0;
  logic [2:0]  operation = 3'd0;
  logic [3:0]  loss_mask = 4'd0;
  logic [1:0]  start_channel = 2'd0;
  logic        busy;
  logic        done;
  logic [1:0]  shown_channel;
  logic        running;
  logic        held;
  logic        switched;

  video_channel_auto_sequencer #(.CHANNELS(NUM_CHANNELS)) uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .start         (start),
    .busy          (busy),
    .operation     (operation),
    .loss_mask     (loss_mask),
    .start_channel (start_channel),
    .done          (done),
    .shown_channel (shown_channel),
    .running       (running),
    .held          (held),
    .switched      (switched)
  );

  sequencer_scoreboard board = new();
  int quiet_cycles = 0;
  bit gaps_on = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: done is a one-cycle strobe, so every done cycle is a result.
  // Outputs are sampled at the edge before the block's own updates land.
  // The watchdog also lives here: it counts edges with no item and no result.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) board.check_selection(shown_channel, running, held, switched);
      if (done || (start && !busy)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Present one item and hold it until the block takes it (start high, busy
  // low at the edge). start is left high so back-to-back items need no
  // toggle; the gap and drain tasks lower it.
  task automatic send_item(input logic [2:0] op, input logic [3:0] loss,
                           input logic [1:0] chan);
    start         <= 1'b1;
    operation     <= op;
    loss_mask     <= loss;
    start_channel <= chan;
    do @(posedge clk); while (busy);
    board.take_command(op, loss, chan);
  endtask

  // mostly short gaps, now and then a long one
  task automatic random_gap();
    int len;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      start <= 1'b0;
      repeat (len) @(posedge clk);
    end
  endtask

  // hold off until every queued selection is back, then let the block settle
  task automatic drain();
    start <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // all three registers, back to back; only called with the block idle
  task automatic load_settings(input logic [31:0] dwell, input logic skip,
                               input logic pip);
    cfg_write <= 1'b1;
    cfg_index <= REG_DWELL;
    cfg_data  <= dwell;
    @(posedge clk);
    cfg_index <= REG_LOSS_SKIP;
    cfg_data  <= {31'd0, skip};
    @(posedge clk);
    cfg_index <= REG_PIP;
    cfg_data  <= {31'd0, pip};
    @(posedge clk);
    cfg_write <= 1'b0;
    board.write_register(REG_DWELL, dwell);
    board.write_register(REG_LOSS_SKIP, {31'd0, skip});
    board.write_register(REG_PIP, {31'd0, pip});
  endtask

  initial begin
    logic [31:0] dwell;
    logic [2:0]  op;
    int          w;
    int          sent;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed: reset settings, dwell 3 on every channel ----
    send_item(OP_TICK, 4'h0, 2'd0);       // tick while stopped
    send_item(OP_LOSS, 4'hF, 2'd3);       // loss update while stopped
    send_item(OP_PAUSE, 4'h0, 2'd0);
    send_item(OP_RESUME, 4'h0, 2'd0);
    send_item(OP_START, 4'h0, 2'd2);      // full-screen start at channel 2
    repeat (4) send_item(OP_TICK, 4'h0, 2'd0);  // count down, expire, switch
    send_item(OP_PAUSE, 4'h0, 2'd0);
    send_item(OP_TICK, 4'h0, 2'd0);       // held: no count
    send_item(OP_RESUME, 4'h0, 2'd0);
    send_item(OP_LOSS, 4'h5, 2'd1);       // loss update with skipping off
    send_item(OP_SPARE_LO, 4'hA, 2'd1);
    send_item(OP_SPARE_HI, 4'h5, 2'd2);
    send_item(OP_START, 4'h0, 2'd0);      // start while running advances
    send_item(OP_STOP, 4'h0, 2'd0);
    drain();

    // skipping on; one channel with dwell 0, one with 255 (reads as skipped)
    load_settings(32'hFF00_0201, 1'b1, 1'b0);
    send_item(OP_START, 4'b0010, 2'd3);
    send_item(OP_TICK, 4'h0, 2'd0);
    send_item(OP_TICK, 4'h0, 2'd0);       // expire with no other channel eligible: stay
    send_item(OP_LOSS, 4'b0001, 2'd0);    // current channel goes lost
    send_item(OP_TICK, 4'h0, 2'd0);       // skipped time: no change
    send_item(OP_LOSS, 4'b0000, 2'd0);
    drain();

    // PIP sequencing: channel 0 never shown
    load_settings(32'h0102_0304, 1'b0, 1'b1);
    send_item(OP_STOP, 4'h0, 2'd0);
    send_item(OP_START, 4'h0, 2'd0);
    drain();

    // ---- random phases, each with its own settings ----
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: dwell = 32'h0000_0000;          // nothing eligible anywhere
        1: dwell = 32'hFFFF_FFFF;          // every channel reads as skipped
        2: dwell = 32'h0101_0101;          // fastest rotation
        default: begin
          for (int b = 0; b < NUM_CHANNELS; b++) begin
            w = $urandom_range(0, 9);
            if (w == 0) dwell[8*b +: 8] = 8'h00;
            else if (w == 1) dwell[8*b +: 8] = 8'hFF;
            else if (w == 2) dwell[8*b +: 8] = 8'($urandom_range(0, 255));
            else dwell[8*b +: 8] = 8'($urandom_range(1, 4));
          end
        end
      endcase
      if (phase < 4) load_settings(dwell, phase[0], phase[1]);
      else load_settings(dwell, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      // some phases run flat out, with no random gaps between items
      gaps_on = (phase != 2) && ($urandom_range(0, 2) != 0);

      // well-formed: begin with a start, then mostly ticks with random content
      send_item(OP_START, 4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)));
      sent = 1;
      while (sent < PHASE_ITEMS) begin
        w = $urandom_range(0, 99);
        if (w < 55) op = OP_TICK;
        else if (w < 67) op = OP_LOSS;
        else if (w < 75) op = OP_START;
        else if (w < 81) op = OP_PAUSE;
        else if (w < 88) op = OP_RESUME;
        else if (w < 93) op = OP_STOP;
        else if (w < 95) op = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
        else op = OP_TICK;
        // a stopped sequencer does little; usually get it going again
        if (!board.active && $urandom_range(0, 3) != 0) op = OP_START;
        send_item(op, 4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)));
        // ignored codes do not count toward the phase length
        if (op != OP_SPARE_LO && op != OP_SPARE_HI) sent++;
        if ($urandom_range(0, 49) == 0) drain();
        else random_gap();
      end
      drain();
    end

    drain();
    if (board.fails == 0 && board.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* video_channel_auto_sequencer.f */
design/vcas_pkg.sv
design/vcas_time_mem.sv
design/vcas_ctrl.sv
design/video_channel_auto_sequencer.sv
test/sequencer_check_pkg.sv
test/video_channel_auto_sequencer_test.sv
